FILE: sv/sorted_priority_notification_queue_top_assert.svh
// Assertion macros used by the queue top level.
`ifndef SORTED_PRIORITY_NOTIFICATION_QUEUE_TOP_ASSERT_SVH
`define SORTED_PRIORITY_NOTIFICATION_QUEUE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SPQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SPQ_ASSERT_SAME(label, ante, cons, msg)
`define SPQ_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: sv/spq_pkg.sv
// Types, constants and helpers of the sorted notification queue.
`timescale 1ns / 1ps
package spq_pkg;
  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;
  localparam int ADDR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int RES_W = $clog2(MAX_RESULTS + 1);
  localparam int HANDLE_W = 16;
  localparam int KIND_W = 2;
  localparam int MODE_W = 2;
  localparam int THR_W = 4;
  localparam int STATUS_W = 2;
  localparam int PRIO_W = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_POP    = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPT  = 2'd0,
    ST_DELIVER = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  localparam logic [KIND_W-1:0] KIND_MAIL  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SMS   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ALARM = 2'd2;

  localparam logic [PRIO_W-1:0] PRIO_MAIL  = 4'd1;
  localparam logic [PRIO_W-1:0] PRIO_SMS   = 4'd5;
  localparam logic [PRIO_W-1:0] PRIO_ALARM = 4'd10;
  localparam logic [PRIO_W-1:0] PRIO_OTHER = 4'd15;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [KIND_W-1:0]   kind;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic [PRIO_W-1:0] prio_of(input logic [KIND_W-1:0] k);
    logic [PRIO_W-1:0] p;
    case (k)
      KIND_MAIL:  p = PRIO_MAIL;
      KIND_SMS:   p = PRIO_SMS;
      KIND_ALARM: p = PRIO_ALARM;
      default:    p = PRIO_OTHER;
    endcase
    return p;
  endfunction
endpackage

FILE: sv/spq_in_if.sv
// Request channel: operation word into the queue.
`timescale 1ns / 1ps
interface spq_in_if import spq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [HANDLE_W-1:0] handle;
  logic [KIND_W-1:0]   kind;
  logic [THR_W-1:0]    threshold;

  modport source (output valid, mode, handle, kind, threshold, input ready);
  modport sink (input valid, mode, handle, kind, threshold, output ready);
endinterface

FILE: sv/spq_out_if.sv
// Response channel: result word out of the queue.
`timescale 1ns / 1ps
interface spq_out_if import spq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] out_handle;
  logic [KIND_W-1:0]   out_kind;
  logic                last;

  modport source (output valid, status, out_handle, out_kind, last, input ready);
  modport sink (input valid, status, out_handle, out_kind, last, output ready);
endinterface

FILE: sv/spq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: sv/sorted_priority_notification_queue_top.sv
// Top level of the sorted notification queue: sequencer, entry RAM, output register.
//
//   channel | dir | word fields
//   req     | in  | mode, handle, kind, threshold
//   rsp     | out | status, out_handle, out_kind, last
//
// One request at a time; req.ready is high only while the sequencer is idle.
// Insert finds its slot and shifts the entries behind it up; pop takes the head and
// shifts the rest down; query scans for priorities below the threshold; full, empty
// or no-op go straight to the response. The entry RAM read is registered.
// A stalled rsp holds the sequencer only where it has a word to hand over.
// Synchronous reset empties the queue; the RAM contents are not cleared.
`timescale 1ns / 1ps
`include "sorted_priority_notification_queue_top_assert.svh"
module sorted_priority_notification_queue_top import spq_pkg::*; (
  input logic     clk,
  input logic     rst,
  spq_in_if.sink  req,
  spq_out_if.source rsp
);
  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CK,
    S_SH_RD,
    S_SH_WR,
    S_POP_ST,
    S_POP_FR,
    S_POP_RD,
    S_POP_WR,
    S_Q_RD,
    S_Q_CK,
    S_FIN
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    occ;
  logic [CNT_W-1:0]    ptr;
  logic [CNT_W-1:0]    pos;
  logic [RES_W-1:0]    nres;
  logic                havep;
  entry_t              pend;
  entry_t              new_entry;
  logic [THR_W-1:0]    thr;
  status_t             res_status;
  entry_t              res;

  logic                o_valid;
  status_t             o_status;
  entry_t              o_word;
  logic                o_last;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;
  entry_t              rd_entry;
  logic [CNT_W-1:0]    ptr_m1;
  logic                out_free;
  logic                ins_before;
  logic                q_match;
  logic                o_load;

  assign rd_entry   = entry_t'(ram_rdata);
  assign ptr_m1     = ptr - 1'b1;
  assign out_free   = !o_valid || rsp.ready;
  assign ins_before = prio_of(rd_entry.kind) < prio_of(new_entry.kind);
  assign q_match    = prio_of(rd_entry.kind) < thr;
  assign o_load     = ((state == S_Q_CK) && q_match && havep && out_free) ||
                      ((state == S_FIN) && out_free);

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = o_valid;
  assign rsp.status     = o_status;
  assign rsp.out_handle = o_word.handle;
  assign rsp.out_kind   = o_word.kind;
  assign rsp.last       = o_last;

  spq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr[ADDR_W-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = ptr[ADDR_W-1:0];
    case (state)
      S_SH_RD: begin
        ram_raddr = ptr_m1[ADDR_W-1:0];
        if (ptr == pos) begin
          ram_we    = 1'b1;
          ram_waddr = pos[ADDR_W-1:0];
          ram_wdata = new_entry;
        end
      end
      S_SH_WR: ram_we = 1'b1;
      S_POP_ST: ram_raddr = '0;
      S_POP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_m1[ADDR_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      occ     <= '0;
      nres    <= '0;
      havep   <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (o_valid && rsp.ready) begin
        o_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            new_entry.handle <= req.handle;
            new_entry.kind   <= req.kind;
            thr              <= req.threshold;
            res              <= '0;
            ptr              <= '0;
            nres             <= '0;
            havep            <= 1'b0;
            case (req.mode)
              MODE_INSERT: begin
                if (occ == CNT_W'(QUEUE_DEPTH)) begin
                  res_status <= ST_FULL;
                  state      <= S_FIN;
                end else begin
                  state <= S_INS_RD;
                end
              end
              MODE_POP: begin
                if (occ == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_FIN;
                end else begin
                  state <= S_POP_ST;
                end
              end
              MODE_QUERY: state <= S_Q_RD;
              default: begin
                res_status <= ST_EMPTY;
                state      <= S_FIN;
              end
            endcase
          end
        end
        S_INS_RD: begin
          if (ptr == occ) begin
            pos   <= ptr;
            ptr   <= occ;
            state <= S_SH_RD;
          end else begin
            state <= S_INS_CK;
          end
        end
        S_INS_CK: begin
          if (ins_before) begin
            ptr   <= ptr + 1'b1;
            state <= S_INS_RD;
          end else begin
            pos   <= ptr;
            ptr   <= occ;
            state <= S_SH_RD;
          end
        end
        S_SH_RD: begin
          if (ptr == pos) begin
            occ        <= occ + 1'b1;
            res_status <= ST_ACCEPT;
            state      <= S_FIN;
          end else begin
            state <= S_SH_WR;
          end
        end
        S_SH_WR: begin
          ptr   <= ptr_m1;
          state <= S_SH_RD;
        end
        S_POP_ST: state <= S_POP_FR;
        S_POP_FR: begin
          res   <= rd_entry;
          ptr   <= CNT_W'(1);
          state <= S_POP_RD;
        end
        S_POP_RD: begin
          if (ptr == occ) begin
            occ        <= occ - 1'b1;
            res_status <= ST_DELIVER;
            state      <= S_FIN;
          end else begin
            state <= S_POP_WR;
          end
        end
        S_POP_WR: begin
          ptr   <= ptr + 1'b1;
          state <= S_POP_RD;
        end
        S_Q_RD: begin
          if (ptr == occ || nres == RES_W'(MAX_RESULTS)) begin
            if (havep) begin
              res_status <= ST_DELIVER;
              res        <= pend;
            end else begin
              res_status <= ST_EMPTY;
            end
            state <= S_FIN;
          end else begin
            state <= S_Q_CK;
          end
        end
        S_Q_CK: begin
          if (!(q_match && havep && !out_free)) begin
            if (q_match) begin
              if (havep) begin
                o_status <= ST_DELIVER;
                o_word   <= pend;
                o_last   <= 1'b0;
              end
              pend  <= rd_entry;
              havep <= 1'b1;
              nres  <= nres + 1'b1;
            end
            ptr   <= ptr + 1'b1;
            state <= S_Q_RD;
          end
        end
        S_FIN: begin
          if (out_free) begin
            o_status <= res_status;
            o_word   <= res;
            o_last   <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SPQ_ASSERT_SAME(a_occ_max, 1'b1, occ <= CNT_W'(QUEUE_DEPTH), "occupancy beyond depth")
  `SPQ_ASSERT_NEXT(a_occ_step, 1'b1, (occ == $past(occ)) || (occ == $past(occ) + 1'b1) || (occ + 1'b1 == $past(occ)), "occupancy jumped")
  `SPQ_ASSERT_NEXT(a_query_keeps, (state == S_Q_CK) || (state == S_Q_RD), occ == $past(occ), "query changed occupancy")
  `SPQ_ASSERT_SAME(a_res_cap, 1'b1, nres <= RES_W'(MAX_RESULTS), "match count beyond cap")
endmodule
